/* rtl/core/bsid_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// bsid_pkg
// Shared types, opcode constants and decode tables for the byte stream
// instruction decoder (8-bit CPU instruction set).
// ============================================================================

package bsid_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int MNEM_W  = 6;
    localparam int OPND_W  = 5;
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 16;

    // Special opcode values and masks
    localparam logic [BYTE_W-1:0] OPC_CB_PREFIX = 8'hCB;
    localparam logic [BYTE_W-1:0] OPC_HALT      = 8'h76;
    localparam logic [BYTE_W-1:0] RST_MASK      = 8'hC7;
    localparam logic [BYTE_W-1:0] RST_VEC_MASK  = 8'h38;

    // Opcode group codes (top two bits of the opcode)
    localparam logic [1:0] GRP_LD  = 2'd1;
    localparam logic [1:0] GRP_ALU = 2'd2;

    // Prefixed group codes (top two bits of the byte after the prefix)
    localparam logic [1:0] CB_GRP_SHIFT = 2'd0;
    localparam logic [1:0] CB_GRP_BIT   = 2'd1;
    localparam logic [1:0] CB_GRP_RES   = 2'd2;

    typedef enum logic [MNEM_W-1:0] {
        MN_NOP, MN_LD, MN_INC, MN_DEC, MN_RLCA, MN_ADD, MN_RRCA, MN_STOP, MN_RLA,
        MN_JR, MN_RRA, MN_LDI, MN_DAA, MN_CPL, MN_LDD, MN_SCF, MN_CCF, MN_HALT,
        MN_ADC, MN_SUB, MN_SBC, MN_AND, MN_XOR, MN_OR, MN_CP, MN_RET, MN_POP,
        MN_JP, MN_CALL, MN_PUSH, MN_RST, MN_RETI, MN_DI, MN_LDHL, MN_EI,
        MN_RLC, MN_RRC, MN_RL, MN_RR, MN_SLA, MN_SRA, MN_SWAP, MN_SRL,
        MN_BIT, MN_RES, MN_SET
    } t_mnem;

    typedef enum logic [OPND_W-1:0] {
        OD_NONE, OD_B, OD_C, OD_D, OD_E, OD_H, OD_L, OD_A, OD_IMM8, OD_IMMS,
        OD_IMM16, OD_BC, OD_DE, OD_HL, OD_SP, OD_AF, OD_PBC, OD_PDE, OD_PHL,
        OD_PIMM8, OD_PIMM16, OD_FNZ, OD_FZ, OD_FNC, OD_FC, OD_PC
    } t_opnd;

    typedef enum logic [KIND_W-1:0] {
        IK_NONE, IK_BYTE, IK_SIGNED, IK_WORD
    } t_imm_kind;

    typedef enum logic [2:0] {
        PH_OPCODE, PH_CB, PH_IMM8, PH_IMMS, PH_IMM16L, PH_IMM16H
    } t_phase;

    // Decoded instruction as presented on the result channel
    typedef struct packed {
        t_mnem               mnemonic;
        t_opnd               first;
        t_opnd               second;
        t_imm_kind           kind;
        logic [VALUE_W-1:0]  value;
        logic                unknown;
    } t_result;

    // Decoder state carried between code bytes
    typedef struct packed {
        t_phase              phase;
        t_mnem               held_mnemonic;
        t_opnd               held_first;
        t_opnd               held_second;
        logic [BYTE_W-1:0]   low_byte;
    } t_dec_state;

    // One entry of the assorted opcode table
    typedef struct packed {
        logic   valid;
        t_mnem  mnemonic;
        t_opnd  first;
        t_opnd  second;
    } t_entry;

    function automatic t_opnd reg_sel(input logic [2:0] idx);
        case (idx)
            3'd0:    return OD_B;
            3'd1:    return OD_C;
            3'd2:    return OD_D;
            3'd3:    return OD_E;
            3'd4:    return OD_H;
            3'd5:    return OD_L;
            3'd6:    return OD_PHL;
            default: return OD_A;
        endcase
    endfunction

    function automatic t_mnem shift_op(input logic [2:0] idx);
        case (idx)
            3'd0:    return MN_RLC;
            3'd1:    return MN_RRC;
            3'd2:    return MN_RL;
            3'd3:    return MN_RR;
            3'd4:    return MN_SLA;
            3'd5:    return MN_SRA;
            3'd6:    return MN_SWAP;
            default: return MN_SRL;
        endcase
    endfunction

    function automatic t_mnem alu_op(input logic [2:0] idx);
        case (idx)
            3'd0:    return MN_ADD;
            3'd1:    return MN_ADC;
            3'd2:    return MN_SUB;
            3'd3:    return MN_SBC;
            3'd4:    return MN_AND;
            3'd5:    return MN_XOR;
            3'd6:    return MN_OR;
            default: return MN_CP;
        endcase
    endfunction

    // Immediate kind implied by one operand
    function automatic t_imm_kind od_kind(input t_opnd od);
        case (od)
            OD_IMMS:              return IK_SIGNED;
            OD_IMM8, OD_PIMM8:    return IK_BYTE;
            OD_IMM16, OD_PIMM16:  return IK_WORD;
            default:              return IK_NONE;
        endcase
    endfunction

    function automatic t_entry mk(input t_mnem m, input t_opnd l, input t_opnd r);
        t_entry e;
        e.valid    = 1'b1;
        e.mnemonic = m;
        e.first    = l;
        e.second   = r;
        return e;
    endfunction

    // Opcodes outside the load, ALU and restart groups
    function automatic t_entry table_lookup(input logic [BYTE_W-1:0] b);
        t_entry none;
        none.valid    = 1'b0;
        none.mnemonic = MN_NOP;
        none.first    = OD_NONE;
        none.second   = OD_NONE;
        case (b)
            8'h00: return mk(MN_NOP, OD_NONE, OD_NONE);
            8'h01: return mk(MN_LD, OD_BC, OD_IMM16);
            8'h02: return mk(MN_LD, OD_PBC, OD_A);
            8'h03: return mk(MN_INC, OD_BC, OD_NONE);
            8'h04: return mk(MN_INC, OD_B, OD_NONE);
            8'h05: return mk(MN_DEC, OD_B, OD_NONE);
            8'h06: return mk(MN_LD, OD_B, OD_IMM8);
            8'h07: return mk(MN_RLCA, OD_NONE, OD_NONE);
            8'h08: return mk(MN_LD, OD_PIMM16, OD_SP);
            8'h09: return mk(MN_ADD, OD_HL, OD_BC);
            8'h0a: return mk(MN_LD, OD_A, OD_PBC);
            8'h0b: return mk(MN_DEC, OD_BC, OD_NONE);
            8'h0c: return mk(MN_INC, OD_C, OD_NONE);
            8'h0d: return mk(MN_DEC, OD_C, OD_NONE);
            8'h0e: return mk(MN_LD, OD_C, OD_IMM8);
            8'h0f: return mk(MN_RRCA, OD_NONE, OD_NONE);
            8'h10: return mk(MN_STOP, OD_NONE, OD_NONE);
            8'h11: return mk(MN_LD, OD_DE, OD_IMM16);
            8'h12: return mk(MN_LD, OD_PDE, OD_A);
            8'h13: return mk(MN_INC, OD_DE, OD_NONE);
            8'h14: return mk(MN_INC, OD_D, OD_NONE);
            8'h15: return mk(MN_DEC, OD_D, OD_NONE);
            8'h16: return mk(MN_LD, OD_D, OD_IMM8);
            8'h17: return mk(MN_RLA, OD_NONE, OD_NONE);
            8'h18: return mk(MN_JR, OD_IMMS, OD_NONE);
            8'h19: return mk(MN_ADD, OD_HL, OD_DE);
            8'h1a: return mk(MN_LD, OD_A, OD_PDE);
            8'h1b: return mk(MN_DEC, OD_DE, OD_NONE);
            8'h1c: return mk(MN_INC, OD_E, OD_NONE);
            8'h1d: return mk(MN_DEC, OD_E, OD_NONE);
            8'h1e: return mk(MN_LD, OD_E, OD_IMM8);
            8'h1f: return mk(MN_RRA, OD_NONE, OD_NONE);
            8'h20: return mk(MN_JR, OD_FNZ, OD_IMMS);
            8'h21: return mk(MN_LD, OD_HL, OD_IMM16);
            8'h22: return mk(MN_LDI, OD_PHL, OD_A);
            8'h23: return mk(MN_INC, OD_HL, OD_NONE);
            8'h24: return mk(MN_INC, OD_H, OD_NONE);
            8'h25: return mk(MN_DEC, OD_H, OD_NONE);
            8'h26: return mk(MN_LD, OD_H, OD_IMM8);
            8'h27: return mk(MN_DAA, OD_NONE, OD_NONE);
            8'h28: return mk(MN_JR, OD_FZ, OD_IMMS);
            8'h29: return mk(MN_ADD, OD_HL, OD_HL);
            8'h2a: return mk(MN_LDI, OD_A, OD_PHL);
            8'h2b: return mk(MN_DEC, OD_HL, OD_NONE);
            8'h2c: return mk(MN_INC, OD_L, OD_NONE);
            8'h2d: return mk(MN_DEC, OD_L, OD_NONE);
            8'h2e: return mk(MN_LD, OD_L, OD_IMM8);
            8'h2f: return mk(MN_CPL, OD_NONE, OD_NONE);
            8'h30: return mk(MN_JR, OD_FNC, OD_IMMS);
            8'h31: return mk(MN_LD, OD_SP, OD_IMM16);
            8'h32: return mk(MN_LDD, OD_PHL, OD_A);
            8'h33: return mk(MN_INC, OD_SP, OD_NONE);
            8'h34: return mk(MN_INC, OD_PHL, OD_NONE);
            8'h35: return mk(MN_DEC, OD_PHL, OD_NONE);
            8'h36: return mk(MN_LD, OD_PHL, OD_IMM8);
            8'h37: return mk(MN_SCF, OD_NONE, OD_NONE);
            8'h38: return mk(MN_JR, OD_FC, OD_IMMS);
            8'h39: return mk(MN_ADD, OD_HL, OD_SP);
            8'h3a: return mk(MN_LDD, OD_A, OD_PHL);
            8'h3b: return mk(MN_DEC, OD_SP, OD_NONE);
            8'h3c: return mk(MN_INC, OD_A, OD_NONE);
            8'h3d: return mk(MN_DEC, OD_A, OD_NONE);
            8'h3e: return mk(MN_LD, OD_A, OD_IMM8);
            8'h3f: return mk(MN_CCF, OD_NONE, OD_NONE);
            8'hc0: return mk(MN_RET, OD_FNZ, OD_NONE);
            8'hc1: return mk(MN_POP, OD_BC, OD_NONE);
            8'hc2: return mk(MN_JP, OD_FNZ, OD_IMM16);
            8'hc3: return mk(MN_JP, OD_IMM16, OD_NONE);
            8'hc4: return mk(MN_CALL, OD_FNZ, OD_IMM16);
            8'hc5: return mk(MN_PUSH, OD_BC, OD_NONE);
            8'hc6: return mk(MN_ADD, OD_A, OD_IMM8);
            8'hc8: return mk(MN_RET, OD_FZ, OD_NONE);
            8'hc9: return mk(MN_RET, OD_NONE, OD_NONE);
            8'hca: return mk(MN_JP, OD_FZ, OD_IMM16);
            8'hcc: return mk(MN_CALL, OD_FZ, OD_IMM16);
            8'hcd: return mk(MN_CALL, OD_IMM16, OD_NONE);
            8'hce: return mk(MN_ADC, OD_A, OD_IMM8);
            8'hd0: return mk(MN_RET, OD_FNC, OD_NONE);
            8'hd1: return mk(MN_POP, OD_DE, OD_NONE);
            8'hd2: return mk(MN_JP, OD_FNC, OD_IMM16);
            8'hd4: return mk(MN_CALL, OD_FNC, OD_IMM16);
            8'hd5: return mk(MN_PUSH, OD_DE, OD_NONE);
            8'hd6: return mk(MN_SUB, OD_IMM8, OD_NONE);
            8'hd8: return mk(MN_RET, OD_FC, OD_NONE);
            8'hd9: return mk(MN_RETI, OD_NONE, OD_NONE);
            8'hda: return mk(MN_JP, OD_FC, OD_IMM16);
            8'hdc: return mk(MN_CALL, OD_FC, OD_IMM16);
            8'hde: return mk(MN_SBC, OD_A, OD_IMM8);
            8'he0: return mk(MN_LD, OD_PIMM8, OD_A);
            8'he1: return mk(MN_POP, OD_HL, OD_NONE);
            8'he2: return mk(MN_LD, OD_PC, OD_A);
            8'he5: return mk(MN_PUSH, OD_HL, OD_NONE);
            8'he6: return mk(MN_AND, OD_IMM8, OD_NONE);
            8'he8: return mk(MN_ADD, OD_SP, OD_IMMS);
            8'he9: return mk(MN_JP, OD_HL, OD_NONE);
            8'hea: return mk(MN_LD, OD_PIMM16, OD_A);
            8'hee: return mk(MN_XOR, OD_IMM8, OD_NONE);
            8'hf0: return mk(MN_LD, OD_A, OD_PIMM8);
            8'hf1: return mk(MN_POP, OD_AF, OD_NONE);
            8'hf2: return mk(MN_LD, OD_A, OD_PC);
            8'hf3: return mk(MN_DI, OD_NONE, OD_NONE);
            8'hf5: return mk(MN_PUSH, OD_AF, OD_NONE);
            8'hf6: return mk(MN_OR, OD_IMM8, OD_NONE);
            8'hf8: return mk(MN_LDHL, OD_SP, OD_IMMS);
            8'hf9: return mk(MN_LD, OD_SP, OD_HL);
            8'hfa: return mk(MN_LD, OD_A, OD_PIMM16);
            8'hfb: return mk(MN_EI, OD_NONE, OD_NONE);
            8'hfe: return mk(MN_CP, OD_IMM8, OD_NONE);
            default: return none;
        endcase
    endfunction

endpackage

/* rtl/core/byte_stream_instruction_decoder_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// byte_stream_instruction_decoder_core
// Decodes an 8-bit CPU instruction byte stream into mnemonic, operands and
// gathered immediate.
// ============================================================================
//
// Usage:
//   Input channel (i_valid / o_stall / i_code_byte) takes one code byte per
//   transfer, in program order. Output channel (o_valid / i_stall / o_*)
//   delivers one decoded instruction per completed instruction: opcode plus
//   its immediate bytes, or prefix plus the following byte.
//   Throughput: one byte per cycle while the result register is free or
//   being taken, set by the single decode pass between the input register
//   and the result register. The byte that completes an instruction is
//   loaded into the input register on its transfer, and its result is
//   loaded into the result register when the pipeline advances.
//   Prefix bytes and leading immediate bytes produce no result.
//   Undefined opcodes give NOP with o_unknown_opcode set.
//   Reset: both stages empty, decoder expects an opcode byte.
//   Receiver stall: the result register holds; the input register holds
//   a byte behind it, and o_stall rises only while both stages are full.
//
// ============================================================================

module byte_stream_instruction_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bsid_pkg::BYTE_W-1:0]   i_code_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bsid_pkg::MNEM_W-1:0]   o_mnemonic,
    output logic [bsid_pkg::OPND_W-1:0]   o_first_operand,
    output logic [bsid_pkg::OPND_W-1:0]   o_second_operand,
    output logic [bsid_pkg::KIND_W-1:0]   o_immediate_kind,
    output logic [bsid_pkg::VALUE_W-1:0]  o_immediate_value,
    output logic                          o_unknown_opcode
);

    logic                        r_in_valid;
    logic [bsid_pkg::BYTE_W-1:0] r_in_byte;
    bsid_pkg::t_dec_state        r_state;
    bsid_pkg::t_dec_state        n_state;
    logic                        r_out_valid;
    bsid_pkg::t_result           r_out;
    bsid_pkg::t_result           n_out;
    logic                        dec_emit;
    logic                        advance;

    // Pipeline moves when the result register is free or being taken
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;

    bsid_dec u_dec (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_next   (n_state),
        .o_emit   (dec_emit),
        .o_result (n_out)
    );

    // Input register: load on transfer, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_code_byte;
        end
    end

    // Decoder state: advance once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= bsid_pkg::PH_OPCODE;
            r_state.held_mnemonic <= bsid_pkg::MN_NOP;
            r_state.held_first    <= bsid_pkg::OD_NONE;
            r_state.held_second   <= bsid_pkg::OD_NONE;
            r_state.low_byte      <= '0;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && dec_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && dec_emit) begin
            r_out <= n_out;
        end
    end

    // Drive the result ports
    assign o_valid           = r_out_valid;
    assign o_mnemonic        = r_out.mnemonic;
    assign o_first_operand   = r_out.first;
    assign o_second_operand  = r_out.second;
    assign o_immediate_kind  = r_out.kind;
    assign o_immediate_value = r_out.value;
    assign o_unknown_opcode  = r_out.unknown;

    // A prefix byte consumed as an opcode moves the decoder to the prefixed phase
    a_prefix_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_state.phase == bsid_pkg::PH_OPCODE &&
         r_in_byte == bsid_pkg::OPC_CB_PREFIX)
        |=> (r_state.phase == bsid_pkg::PH_CB && !r_out_valid))
        else $error("prefix byte did not enter prefixed phase");

    // The low immediate byte is always followed by the high byte phase
    a_word_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_state.phase == bsid_pkg::PH_IMM16L)
        |=> (r_state.phase == bsid_pkg::PH_IMM16H && r_state.low_byte == $past(r_in_byte)))
        else $error("low immediate byte not captured");

    // No immediate kind means a zero value
    a_no_imm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == bsid_pkg::IK_NONE) |-> (r_out.value == '0))
        else $error("value present without immediate");

    // An undefined opcode reports a bare NOP
    a_unknown_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.unknown) |->
        (r_out.mnemonic == bsid_pkg::MN_NOP && r_out.first == bsid_pkg::OD_NONE &&
         r_out.second == bsid_pkg::OD_NONE && r_out.kind == bsid_pkg::IK_NONE))
        else $error("unknown opcode result is not a bare NOP");

    // Every emitted instruction returns the decoder to the opcode phase
    a_emit_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && dec_emit) |=> (r_state.phase == bsid_pkg::PH_OPCODE))
        else $error("phase not reset after result");

endmodule

/* rtl/core/bsid_dec.sv */
`timescale 1ns / 1ps
// ============================================================================
// bsid_dec
// Combinational decode of one code byte against the current decoder state:
// produces the next state and, when an instruction completes, its result.
// ============================================================================

module bsid_dec (
    input  logic [bsid_pkg::BYTE_W-1:0] i_byte,
    input  bsid_pkg::t_dec_state        i_state,
    output bsid_pkg::t_dec_state        o_next,
    output logic                        o_emit,
    output bsid_pkg::t_result           o_result
);

    logic [1:0]          grp;
    logic [2:0]          row;
    logic [2:0]          col;
    bsid_pkg::t_entry    ent;
    bsid_pkg::t_imm_kind k1;
    bsid_pkg::t_imm_kind k2;
    bsid_pkg::t_imm_kind kind;
    bsid_pkg::t_mnem     alu;

    // Split the opcode into its group, row and column fields
    assign grp = i_byte[7:6];
    assign row = i_byte[5:3];
    assign col = i_byte[2:0];

    // Table lookup and immediate kind of the assorted opcodes
    always_comb begin
        ent = bsid_pkg::table_lookup(i_byte);
        k1  = bsid_pkg::od_kind(ent.first);
        k2  = bsid_pkg::od_kind(ent.second);
        alu = bsid_pkg::alu_op(row);
        if (k1 == bsid_pkg::IK_SIGNED || k2 == bsid_pkg::IK_SIGNED) begin
            kind = bsid_pkg::IK_SIGNED;
        end else if (k1 == bsid_pkg::IK_BYTE || k2 == bsid_pkg::IK_BYTE) begin
            kind = bsid_pkg::IK_BYTE;
        end else if (k1 == bsid_pkg::IK_WORD || k2 == bsid_pkg::IK_WORD) begin
            kind = bsid_pkg::IK_WORD;
        end else begin
            kind = bsid_pkg::IK_NONE;
        end
    end

    // Decode by phase
    always_comb begin
        o_next              = i_state;
        o_emit              = 1'b0;
        o_result.mnemonic   = bsid_pkg::MN_NOP;
        o_result.first      = bsid_pkg::OD_NONE;
        o_result.second     = bsid_pkg::OD_NONE;
        o_result.kind       = bsid_pkg::IK_NONE;
        o_result.value      = '0;
        o_result.unknown    = 1'b0;

        case (i_state.phase)
            bsid_pkg::PH_CB: begin
                o_emit       = 1'b1;
                o_next.phase = bsid_pkg::PH_OPCODE;
                if (grp == bsid_pkg::CB_GRP_SHIFT) begin
                    o_result.mnemonic = bsid_pkg::shift_op(row);
                    o_result.first    = bsid_pkg::reg_sel(col);
                end else begin
                    case (grp)
                        bsid_pkg::CB_GRP_BIT: o_result.mnemonic = bsid_pkg::MN_BIT;
                        bsid_pkg::CB_GRP_RES: o_result.mnemonic = bsid_pkg::MN_RES;
                        default:              o_result.mnemonic = bsid_pkg::MN_SET;
                    endcase
                    o_result.first  = bsid_pkg::OD_IMM8;
                    o_result.second = bsid_pkg::reg_sel(col);
                    o_result.kind   = bsid_pkg::IK_BYTE;
                    o_result.value  = {13'd0, row};
                end
            end

            bsid_pkg::PH_IMM8: begin
                o_emit            = 1'b1;
                o_next.phase      = bsid_pkg::PH_OPCODE;
                o_result.mnemonic = i_state.held_mnemonic;
                o_result.first    = i_state.held_first;
                o_result.second   = i_state.held_second;
                o_result.kind     = bsid_pkg::IK_BYTE;
                o_result.value    = {8'd0, i_byte};
            end

            bsid_pkg::PH_IMMS: begin
                o_emit            = 1'b1;
                o_next.phase      = bsid_pkg::PH_OPCODE;
                o_result.mnemonic = i_state.held_mnemonic;
                o_result.first    = i_state.held_first;
                o_result.second   = i_state.held_second;
                o_result.kind     = bsid_pkg::IK_SIGNED;
                o_result.value    = {{8{i_byte[7]}}, i_byte};
            end

            bsid_pkg::PH_IMM16L: begin
                // Hold the low byte, wait for the high one
                o_next.low_byte = i_byte;
                o_next.phase    = bsid_pkg::PH_IMM16H;
            end

            bsid_pkg::PH_IMM16H: begin
                o_emit            = 1'b1;
                o_next.phase      = bsid_pkg::PH_OPCODE;
                o_result.mnemonic = i_state.held_mnemonic;
                o_result.first    = i_state.held_first;
                o_result.second   = i_state.held_second;
                o_result.kind     = bsid_pkg::IK_WORD;
                o_result.value    = {i_byte, i_state.low_byte};
            end

            default: begin
                // Opcode byte; unused phase codes land here as well
                o_next.phase = bsid_pkg::PH_OPCODE;
                if (i_byte == bsid_pkg::OPC_CB_PREFIX) begin
                    o_next.phase = bsid_pkg::PH_CB;
                end else if ((i_byte & bsid_pkg::RST_MASK) == bsid_pkg::RST_MASK) begin
                    o_emit            = 1'b1;
                    o_result.mnemonic = bsid_pkg::MN_RST;
                    o_result.first    = bsid_pkg::OD_IMM8;
                    o_result.kind     = bsid_pkg::IK_BYTE;
                    o_result.value    = {8'd0, i_byte & bsid_pkg::RST_VEC_MASK};
                end else if (grp == bsid_pkg::GRP_LD) begin
                    o_emit = 1'b1;
                    if (i_byte == bsid_pkg::OPC_HALT) begin
                        o_result.mnemonic = bsid_pkg::MN_HALT;
                    end else begin
                        o_result.mnemonic = bsid_pkg::MN_LD;
                        o_result.first    = bsid_pkg::reg_sel(row);
                        o_result.second   = bsid_pkg::reg_sel(col);
                    end
                end else if (grp == bsid_pkg::GRP_ALU) begin
                    o_emit            = 1'b1;
                    o_result.mnemonic = alu;
                    if (alu == bsid_pkg::MN_ADD || alu == bsid_pkg::MN_ADC ||
                        alu == bsid_pkg::MN_SBC) begin
                        o_result.first  = bsid_pkg::OD_A;
                        o_result.second = bsid_pkg::reg_sel(col);
                    end else begin
                        o_result.first  = bsid_pkg::reg_sel(col);
                    end
                end else if (!ent.valid) begin
                    // Undefined opcode: substitute NOP and flag it
                    o_emit           = 1'b1;
                    o_result.unknown = 1'b1;
                end else begin
                    o_next.held_mnemonic = ent.mnemonic;
                    o_next.held_first    = ent.first;
                    o_next.held_second   = ent.second;
                    case (kind)
                        bsid_pkg::IK_NONE: begin
                            o_emit            = 1'b1;
                            o_result.mnemonic = ent.mnemonic;
                            o_result.first    = ent.first;
                            o_result.second   = ent.second;
                        end
                        bsid_pkg::IK_BYTE:   o_next.phase = bsid_pkg::PH_IMM8;
                        bsid_pkg::IK_SIGNED: o_next.phase = bsid_pkg::PH_IMMS;
                        default:             o_next.phase = bsid_pkg::PH_IMM16L;
                    endcase
                end
            end
        endcase
    end

endmodule

/* test/bsid_decode_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// bsid_decode_checker
// Watches both channels of the byte stream instruction decoder, decodes every
// accepted code byte with its own instruction decoder and compares each
// delivered instruction, field by field, against the oldest pending prediction.
// ============================================================================

module bsid_decode_checker
    import bsid_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [BYTE_W-1:0]    i_code_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [MNEM_W-1:0]    i_mnemonic,
    input  logic [OPND_W-1:0]    i_first_operand,
    input  logic [OPND_W-1:0]    i_second_operand,
    input  logic [KIND_W-1:0]    i_immediate_kind,
    input  logic [VALUE_W-1:0]   i_immediate_value,
    input  logic                 i_unknown_opcode,
    output int                   o_pending_decodes,
    output int                   o_fail_count
);

    // Top two opcode bits of the low quadrant outside the load and ALU groups
    localparam logic [1:0] QUAD_MISC_LOW  = 2'd0;

    // Decoder state mirrored from the byte stream
    t_phase              decode_state;
    t_mnem               held_mnem;
    t_opnd               held_first;
    t_opnd               held_second;
    logic [BYTE_W-1:0]   low_byte;

    t_result             expected_decodes [$];
    int                  mismatch_count = 0;

    // Eight-bit register or (HL) selected by a three-bit field
    function automatic t_opnd reg8_operand(input logic [2:0] sel);
        case (sel)
            3'd0:    return OD_B;
            3'd1:    return OD_C;
            3'd2:    return OD_D;
            3'd3:    return OD_E;
            3'd4:    return OD_H;
            3'd5:    return OD_L;
            3'd6:    return OD_PHL;
            default: return OD_A;
        endcase
    endfunction

    // Register pair; the last slot is SP for arithmetic, AF for push and pop
    function automatic t_opnd pair_operand(input logic [1:0] sel, input bit stack_form);
        case (sel)
            2'd0:    return OD_BC;
            2'd1:    return OD_DE;
            2'd2:    return OD_HL;
            default: return stack_form ? OD_AF : OD_SP;
        endcase
    endfunction

    function automatic t_opnd cond_operand(input logic [1:0] sel);
        case (sel)
            2'd0:    return OD_FNZ;
            2'd1:    return OD_FZ;
            2'd2:    return OD_FNC;
            default: return OD_FC;
        endcase
    endfunction

    function automatic t_mnem arith_mnem(input logic [2:0] sel);
        case (sel)
            3'd0:    return MN_ADD;
            3'd1:    return MN_ADC;
            3'd2:    return MN_SUB;
            3'd3:    return MN_SBC;
            3'd4:    return MN_AND;
            3'd5:    return MN_XOR;
            3'd6:    return MN_OR;
            default: return MN_CP;
        endcase
    endfunction

    function automatic t_mnem rotate_mnem(input logic [2:0] sel);
        case (sel)
            3'd0:    return MN_RLC;
            3'd1:    return MN_RRC;
            3'd2:    return MN_RL;
            3'd3:    return MN_RR;
            3'd4:    return MN_SLA;
            3'd5:    return MN_SRA;
            3'd6:    return MN_SWAP;
            default: return MN_SRL;
        endcase
    endfunction

    function automatic t_imm_kind operand_imm(input t_opnd od);
        if (od == OD_IMMS)
            return IK_SIGNED;
        if (od == OD_IMM8 || od == OD_PIMM8)
            return IK_BYTE;
        if (od == OD_IMM16 || od == OD_PIMM16)
            return IK_WORD;
        return IK_NONE;
    endfunction

    function automatic t_result decoded(input t_mnem m, input t_opnd l, input t_opnd r,
                                        input t_imm_kind k, input logic [VALUE_W-1:0] v,
                                        input logic unk);
        t_result res;
        res.mnemonic = m;
        res.first    = l;
        res.second   = r;
        res.kind     = k;
        res.value    = v;
        res.unknown  = unk;
        return res;
    endfunction

    // Decode an opcode from the two quadrants with the irregular layout
    task automatic decode_misc(input logic [7:0] b, output t_mnem mn, output t_opnd lo,
                               output t_opnd ro, output bit known);
        logic [2:0] y;
        logic [2:0] z;
        logic [1:0] p;
        logic       q;
        y = b[5:3];
        z = b[2:0];
        p = b[5:4];
        q = b[3];
        mn = MN_NOP;
        lo = OD_NONE;
        ro = OD_NONE;
        known = 1'b1;
        if (b[7:6] == QUAD_MISC_LOW) begin
            case (z)
                3'd0: begin
                    case (y)
                        3'd0: mn = MN_NOP;
                        3'd1: begin mn = MN_LD; lo = OD_PIMM16; ro = OD_SP; end
                        3'd2: mn = MN_STOP;
                        3'd3: begin mn = MN_JR; lo = OD_IMMS; end
                        default: begin mn = MN_JR; lo = cond_operand(y[1:0]); ro = OD_IMMS; end
                    endcase
                end
                3'd1: begin
                    if (q) begin
                        mn = MN_ADD; lo = OD_HL; ro = pair_operand(p, 1'b0);
                    end else begin
                        mn = MN_LD; lo = pair_operand(p, 1'b0); ro = OD_IMM16;
                    end
                end
                3'd2: begin
                    mn = (p == 2'd2) ? MN_LDI : (p == 2'd3) ? MN_LDD : MN_LD;
                    lo = (p == 2'd0) ? OD_PBC : (p == 2'd1) ? OD_PDE : OD_PHL;
                    ro = OD_A;
                    if (q) begin
                        ro = lo;
                        lo = OD_A;
                    end
                end
                3'd3: begin mn = q ? MN_DEC : MN_INC; lo = pair_operand(p, 1'b0); end
                3'd4: begin mn = MN_INC; lo = reg8_operand(y); end
                3'd5: begin mn = MN_DEC; lo = reg8_operand(y); end
                3'd6: begin mn = MN_LD; lo = reg8_operand(y); ro = OD_IMM8; end
                default: begin
                    case (y)
                        3'd0:    mn = MN_RLCA;
                        3'd1:    mn = MN_RRCA;
                        3'd2:    mn = MN_RLA;
                        3'd3:    mn = MN_RRA;
                        3'd4:    mn = MN_DAA;
                        3'd5:    mn = MN_CPL;
                        3'd6:    mn = MN_SCF;
                        default: mn = MN_CCF;
                    endcase
                end
            endcase
        end else begin
            case (z)
                3'd0: begin
                    case (y)
                        3'd4:    begin mn = MN_LD; lo = OD_PIMM8; ro = OD_A; end
                        3'd5:    begin mn = MN_ADD; lo = OD_SP; ro = OD_IMMS; end
                        3'd6:    begin mn = MN_LD; lo = OD_A; ro = OD_PIMM8; end
                        3'd7:    begin mn = MN_LDHL; lo = OD_SP; ro = OD_IMMS; end
                        default: begin mn = MN_RET; lo = cond_operand(y[1:0]); end
                    endcase
                end
                3'd1: begin
                    if (!q) begin
                        mn = MN_POP; lo = pair_operand(p, 1'b1);
                    end else begin
                        case (p)
                            2'd0:    mn = MN_RET;
                            2'd1:    mn = MN_RETI;
                            2'd2:    begin mn = MN_JP; lo = OD_HL; end
                            default: begin mn = MN_LD; lo = OD_SP; ro = OD_HL; end
                        endcase
                    end
                end
                3'd2: begin
                    case (y)
                        3'd4:    begin mn = MN_LD; lo = OD_PC; ro = OD_A; end
                        3'd5:    begin mn = MN_LD; lo = OD_PIMM16; ro = OD_A; end
                        3'd6:    begin mn = MN_LD; lo = OD_A; ro = OD_PC; end
                        3'd7:    begin mn = MN_LD; lo = OD_A; ro = OD_PIMM16; end
                        default: begin mn = MN_JP; lo = cond_operand(y[1:0]); ro = OD_IMM16; end
                    endcase
                end
                3'd3: begin
                    case (y)
                        3'd0:    begin mn = MN_JP; lo = OD_IMM16; end
                        3'd6:    mn = MN_DI;
                        3'd7:    mn = MN_EI;
                        default: known = 1'b0;
                    endcase
                end
                3'd4: begin
                    if (y[2])
                        known = 1'b0;
                    else begin
                        mn = MN_CALL; lo = cond_operand(y[1:0]); ro = OD_IMM16;
                    end
                end
                3'd5: begin
                    if (!q) begin
                        mn = MN_PUSH; lo = pair_operand(p, 1'b1);
                    end else if (p == 2'd0) begin
                        mn = MN_CALL; lo = OD_IMM16;
                    end else begin
                        known = 1'b0;
                    end
                end
                default: begin
                    // Arithmetic with an immediate byte as source
                    mn = arith_mnem(y);
                    if (mn == MN_ADD || mn == MN_ADC || mn == MN_SBC) begin
                        lo = OD_A; ro = OD_IMM8;
                    end else begin
                        lo = OD_IMM8;
                    end
                end
            endcase
        end
    endtask

    // Advance the mirrored decoder by one code byte
    task automatic decode_code_byte(input logic [7:0] b, output bit emits, output t_result res);
        t_phase      prior;
        t_mnem       mn;
        t_opnd       lo;
        t_opnd       ro;
        bit          known;
        t_imm_kind   k1;
        t_imm_kind   k2;
        t_imm_kind   k;
        prior = decode_state;
        decode_state = PH_OPCODE;
        emits = 1'b1;
        res = '0;
        case (prior)
            PH_CB: begin
                if (b[7:6] == CB_GRP_SHIFT)
                    res = decoded(rotate_mnem(b[5:3]), reg8_operand(b[2:0]), OD_NONE,
                                  IK_NONE, '0, 1'b0);
                else
                    res = decoded((b[7:6] == CB_GRP_BIT) ? MN_BIT :
                                  (b[7:6] == CB_GRP_RES) ? MN_RES : MN_SET,
                                  OD_IMM8, reg8_operand(b[2:0]), IK_BYTE,
                                  {13'd0, b[5:3]}, 1'b0);
            end
            PH_IMM8:
                res = decoded(held_mnem, held_first, held_second, IK_BYTE, {8'h00, b}, 1'b0);
            PH_IMMS:
                res = decoded(held_mnem, held_first, held_second, IK_SIGNED,
                              {{8{b[7]}}, b}, 1'b0);
            PH_IMM16L: begin
                low_byte = b;
                decode_state = PH_IMM16H;
                emits = 1'b0;
            end
            PH_IMM16H:
                res = decoded(held_mnem, held_first, held_second, IK_WORD, {b, low_byte}, 1'b0);
            default: begin
                if (b == OPC_CB_PREFIX) begin
                    decode_state = PH_CB;
                    emits = 1'b0;
                end else if ((b & RST_MASK) == RST_MASK) begin
                    res = decoded(MN_RST, OD_IMM8, OD_NONE, IK_BYTE,
                                  {8'h00, b & RST_VEC_MASK}, 1'b0);
                end else if (b[7:6] == GRP_LD) begin
                    if (b == OPC_HALT)
                        res = decoded(MN_HALT, OD_NONE, OD_NONE, IK_NONE, '0, 1'b0);
                    else
                        res = decoded(MN_LD, reg8_operand(b[5:3]), reg8_operand(b[2:0]),
                                      IK_NONE, '0, 1'b0);
                end else if (b[7:6] == GRP_ALU) begin
                    mn = arith_mnem(b[5:3]);
                    if (mn == MN_ADD || mn == MN_ADC || mn == MN_SBC)
                        res = decoded(mn, OD_A, reg8_operand(b[2:0]), IK_NONE, '0, 1'b0);
                    else
                        res = decoded(mn, reg8_operand(b[2:0]), OD_NONE, IK_NONE, '0, 1'b0);
                end else begin
                    decode_misc(b, mn, lo, ro, known);
                    if (!known) begin
                        res = decoded(MN_NOP, OD_NONE, OD_NONE, IK_NONE, '0, 1'b1);
                    end else begin
                        k1 = operand_imm(lo);
                        k2 = operand_imm(ro);
                        if (k1 == IK_SIGNED || k2 == IK_SIGNED)
                            k = IK_SIGNED;
                        else if (k1 == IK_BYTE || k2 == IK_BYTE)
                            k = IK_BYTE;
                        else if (k1 == IK_WORD || k2 == IK_WORD)
                            k = IK_WORD;
                        else
                            k = IK_NONE;
                        if (k == IK_NONE) begin
                            res = decoded(mn, lo, ro, IK_NONE, '0, 1'b0);
                        end else begin
                            // Hold the instruction until its immediate is in
                            held_mnem   = mn;
                            held_first  = lo;
                            held_second = ro;
                            decode_state = (k == IK_BYTE) ? PH_IMM8 :
                                           (k == IK_SIGNED) ? PH_IMMS : PH_IMM16L;
                            emits = 1'b0;
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare delivered instructions, then predict from accepted code bytes
    always @(posedge i_clk) begin
        t_result   want;
        bit        emits;
        if (!i_rst_n) begin
            decode_state = PH_OPCODE;
            held_mnem    = MN_NOP;
            held_first   = OD_NONE;
            held_second  = OD_NONE;
            low_byte     = '0;
            expected_decodes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_decodes.size() == 0) begin
                    $error("unexpected instruction transfer: mnemonic %0d", i_mnemonic);
                    mismatch_count++;
                end else begin
                    want = expected_decodes.pop_front();
                    check_field("mnemonic", want.mnemonic, i_mnemonic);
                    check_field("first_operand", want.first, i_first_operand);
                    check_field("second_operand", want.second, i_second_operand);
                    check_field("immediate_kind", want.kind, i_immediate_kind);
                    check_field("immediate_value", want.value, i_immediate_value);
                    check_field("unknown_opcode", want.unknown, i_unknown_opcode);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_code_byte(i_code_byte, emits, want);
                if (emits)
                    expected_decodes.push_back(want);
            end
        end
        o_pending_decodes <= expected_decodes.size();
        o_fail_count      <= mismatch_count;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Feeds the byte stream instruction decoder a directed instruction mix and
// then random code streams under changing sender and receiver idling, with a
// long receiver hold-off and full drains; the checker judges each result.
// ============================================================================

module tb;
    import bsid_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_BYTES  = 615;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_code_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic [MNEM_W-1:0]     o_mnemonic;
    logic [OPND_W-1:0]     o_first_operand;
    logic [OPND_W-1:0]     o_second_operand;
    logic [KIND_W-1:0]     o_immediate_kind;
    logic [VALUE_W-1:0]    o_immediate_value;
    logic                  o_unknown_opcode;

    int                    pending_decodes;
    int                    fail_count;
    int                    sender_idle_pct;
    int                    recv_idle_pct;
    int                    hold_requests;
    int                    holds_done;
    int                    hold_cycles;
    int                    cycle_count;
    logic [BYTE_W-1:0]     directed_stream [0:23];

    always #2 i_clk = ~i_clk;

    byte_stream_instruction_decoder_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_code_byte       (i_code_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_mnemonic        (o_mnemonic),
        .o_first_operand   (o_first_operand),
        .o_second_operand  (o_second_operand),
        .o_immediate_kind  (o_immediate_kind),
        .o_immediate_value (o_immediate_value),
        .o_unknown_opcode  (o_unknown_opcode)
    );

    bsid_decode_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_code_byte       (i_code_byte),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_mnemonic        (o_mnemonic),
        .i_first_operand   (o_first_operand),
        .i_second_operand  (o_second_operand),
        .i_immediate_kind  (o_immediate_kind),
        .i_immediate_value (o_immediate_value),
        .i_unknown_opcode  (o_unknown_opcode),
        .o_pending_decodes (pending_decodes),
        .o_fail_count      (fail_count)
    );

    // Random code byte, biased toward the prefix and the value extremes
    function automatic logic [BYTE_W-1:0] random_code_byte();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return OPC_CB_PREFIX;
        if (pick < 12)
            return 8'h00;
        if (pick < 16)
            return 8'hFF;
        return BYTE_W'($urandom_range(255));
    endfunction

    // Offer one code byte after a random idle gap; return at its transfer
    task automatic send_code_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_decodes != 0);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        i_stall    <= 1'b0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_code_byte   <= '0;
        recv_idle_pct <= 0;
        hold_requests <= 0;
        sender_idle_pct = 0;
        // NOP, RST 38, HALT, LD, ALU, undefined opcode, prefixed rotate, SET and
        // BIT, prefix byte taken as data, signed and word immediates at extremes
        directed_stream = '{8'h00, 8'hFF, 8'h76, 8'h40, 8'h80, 8'hD3,
                            8'hCB, 8'h00, 8'hCB, 8'hFF, 8'hCB, 8'h46,
                            8'h06, 8'hCB, 8'h18, 8'h80, 8'h20, 8'h7F,
                            8'h01, 8'h34, 8'h12, 8'hC3, 8'hFF, 8'hFF};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Slow sender, busy receiver
        sender_idle_pct = 36;
        recv_idle_pct   <= 77;
        foreach (directed_stream[n])
            send_code_byte(directed_stream[n]);
        repeat (PHASE_BYTES) send_code_byte(random_code_byte());
        i_valid <= 1'b0;
        wait_drained();

        // Slower sender, less busy receiver
        sender_idle_pct = 77;
        recv_idle_pct   <= 36;
        repeat (PHASE_BYTES) send_code_byte(random_code_byte());
        i_valid <= 1'b0;
        wait_drained();

        // Full rate, with one long receiver hold-off at the start
        sender_idle_pct = 0;
        recv_idle_pct   <= 0;
        hold_requests   <= 1;
        repeat (PHASE_BYTES) send_code_byte(random_code_byte());
        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_decodes == 0) begin
            $display("Test completed successfully");
        end else begin
            if (pending_decodes != 0)
                $error("%0d predicted instructions never delivered", pending_decodes);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
